/* rtl/itoa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned RADIX_W        = 5;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = RADIX_W;
  localparam int unsigned DIV_STEP       = 8;
  localparam int unsigned JOB_DEPTH      = 2;
  localparam int unsigned OUT_DEPTH      = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UP_BASE = 8'h37;
  localparam logic [CHAR_W-1:0] CHAR_LO_BASE = 8'h57;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX = 1'b0,
    REG_UPPER = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_DIGITS,
    ST_ERR
  } back_state_e;

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_MINUS,
    KIND_ERROR
  } char_kind_e;

  typedef struct packed {
    logic               err;
    logic               neg_sign;
    logic               upper;
    logic [RADIX_W-1:0] radix;
  } job_ctrl_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              error;
  } out_item_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + ext;
    end
    return (upper ? CHAR_UP_BASE : CHAR_LO_BASE) + ext;
  endfunction

endpackage

`default_nettype wire

/* rtl/integer_to_radix_ascii_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                                 | transaction when
// ----------+---------------------------------------+-------------------------------
// input     | push, full, value_i                   | push && !full
// result    | empty, pop, character_o, last_o,      | pop && !empty
//           | error_o                               |
// config    | wr_en_i, wr_idx_i, wr_data_i          | wr_en_i (0 radix, 1 upper_case)
//
// each digit is one division of the value by the radix in the 8-bit-per-cycle divider
// two input transactions queue ahead of the converter, four characters behind it
// reset brings radix to 10, lower case letters and both queues empty

module integer_to_radix_ascii_top #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_en_i,
  input  wire logic [itoa_pkg::CFG_IDX_W-1:0]  wr_idx_i,
  input  wire logic [itoa_pkg::CFG_DATA_W-1:0] wr_data_i,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [itoa_pkg::VALUE_W-1:0]    value_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [itoa_pkg::CHAR_W-1:0]          character_o,
  output logic                                 last_o,
  output logic                                 error_o
);

  import itoa_pkg::*;

  localparam int unsigned JOB_W = $bits(job_ctrl_t) + VALUE_BITS;
  localparam int unsigned OUT_W = $bits(out_item_t);

  logic                  job_push;
  job_ctrl_t             front_ctrl;
  logic [VALUE_BITS-1:0] front_mag;
  logic [JOB_W-1:0]      job_rd_data;
  logic                  job_empty;
  logic                  job_pop;
  job_ctrl_t             back_ctrl;
  logic [VALUE_BITS-1:0] back_mag;
  logic                  out_full;
  logic                  out_push;
  out_item_t             back_item;
  out_item_t             head_item;

  itoa_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en_i),
    .wr_idx_i   (wr_idx_i),
    .wr_data_i  (wr_data_i),
    .push_i     (push),
    .value_i    (value_i),
    .job_full_i (full),
    .job_push_o (job_push),
    .job_ctrl_o (front_ctrl),
    .job_mag_o  (front_mag)
  );

  itoa_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(JOB_DEPTH)
  ) u_job_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (job_push),
    .wr_data_i ({front_ctrl, front_mag}),
    .full_o    (full),
    .rd_en_i   (job_pop),
    .rd_data_o (job_rd_data),
    .empty_o   (job_empty)
  );

  assign back_ctrl = job_rd_data[JOB_W-1:VALUE_BITS];
  assign back_mag  = job_rd_data[VALUE_BITS-1:0];

  itoa_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!job_empty),
    .job_ctrl_i  (back_ctrl),
    .job_mag_i   (back_mag),
    .job_pop_o   (job_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_item_o  (back_item)
  );

  itoa_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (out_push),
    .wr_data_i (back_item),
    .full_o    (out_full),
    .rd_en_i   (pop),
    .rd_data_o (head_item),
    .empty_o   (empty)
  );

  assign character_o = head_item.character;
  assign last_o      = head_item.last;
  assign error_o     = head_item.error;

endmodule

`default_nettype wire

/* rtl/itoa_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module itoa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_en_i,
  output logic [WIDTH-1:0]      rd_data_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/itoa_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module itoa_front #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             wr_en_i,
  input  wire logic [itoa_pkg::CFG_IDX_W-1:0]   wr_idx_i,
  input  wire logic [itoa_pkg::CFG_DATA_W-1:0]  wr_data_i,
  input  wire logic                             push_i,
  input  wire logic [itoa_pkg::VALUE_W-1:0]     value_i,
  input  wire logic                             job_full_i,
  output logic                                  job_push_o,
  output itoa_pkg::job_ctrl_t                   job_ctrl_o,
  output logic [VALUE_BITS-1:0]                 job_mag_o
);

  import itoa_pkg::*;

  logic [RADIX_W-1:0]    radix_q;
  logic                  upper_q;
  logic [VALUE_BITS-1:0] raw;
  logic                  neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
      upper_q <= 1'b0;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        REG_RADIX: radix_q <= wr_data_i[RADIX_W-1:0];
        REG_UPPER: upper_q <= wr_data_i[0];
        default:   ;
      endcase
    end
  end

  // two's complement negate also covers the most negative value
  assign raw        = value_i[VALUE_BITS-1:0];
  assign neg        = raw[VALUE_BITS-1];
  assign job_mag_o  = neg ? (~raw + 1'b1) : raw;
  assign job_push_o = push_i && !job_full_i;

  always_comb begin
    job_ctrl_o.err      = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);
    job_ctrl_o.neg_sign = neg && (radix_q == RADIX_DEC);
    job_ctrl_o.upper    = upper_q;
    job_ctrl_o.radix    = radix_q;
  end

endmodule

`default_nettype wire

/* rtl/itoa_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module itoa_back #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  job_valid_i,
  input  wire itoa_pkg::job_ctrl_t   job_ctrl_i,
  input  wire logic [VALUE_BITS-1:0] job_mag_i,
  output logic                       job_pop_o,
  input  wire logic                  out_full_i,
  output logic                       out_push_o,
  output itoa_pkg::out_item_t        out_item_o
);

  import itoa_pkg::*;

  localparam int unsigned CHUNKS = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned DIV_W  = CHUNKS * DIV_STEP;
  localparam int unsigned CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned ADDR_W = $clog2(VALUE_BITS);
  localparam int unsigned ND_W   = $clog2(VALUE_BITS + 1);

  back_state_e         state_q, state_d;
  job_ctrl_t           ctrl_q;
  logic [DIV_W-1:0]    quo_q;
  logic [DIGIT_W-1:0]  rem_q;
  logic [CNT_W-1:0]    chunk_q;
  logic [ND_W-1:0]     nd_q;
  logic [ADDR_W-1:0]   rd_ptr_q;
  logic [DIGIT_W-1:0]  digit_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]  rd_data_q;

  logic                s1_valid_q;
  char_kind_e          s1_kind_q;
  logic                s1_last_q;
  logic                s1_upper_q;

  logic [DIV_W-1:0]    div_quo;
  logic [DIGIT_W-1:0]  div_rem;
  logic                div_done;
  logic                s1_adv;
  logic                issue;
  char_kind_e          issue_kind;
  logic                issue_last;
  logic                load;

  // eight restoring division steps per cycle, quotient bits shift in from the bottom
  always_comb begin : div_step
    logic [DIGIT_W:0] r;
    logic [DIV_W-1:0] q;
    r = {1'b0, rem_q};
    q = quo_q;
    for (int i = 0; i < DIV_STEP; i++) begin
      r = {r[DIGIT_W-1:0], q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (r >= ctrl_q.radix) begin
        r    = r - ctrl_q.radix;
        q[0] = 1'b1;
      end
    end
    div_quo = q;
    div_rem = r[DIGIT_W-1:0];
  end

  assign div_done = (chunk_q == CNT_W'(CHUNKS - 1));
  assign s1_adv   = !s1_valid_q || !out_full_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = job_ctrl_i.err ? ST_ERR : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done && (div_quo == '0)) begin
          state_d = ctrl_q.neg_sign ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (issue) begin
          state_d = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (issue && (rd_ptr_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (issue) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    issue      = 1'b0;
    issue_kind = KIND_DIGIT;
    issue_last = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        load = job_valid_i;
      end
      ST_DIV: ;
      ST_SIGN: begin
        issue      = s1_adv;
        issue_kind = KIND_MINUS;
      end
      ST_DIGITS: begin
        issue      = s1_adv;
        issue_last = (rd_ptr_q == '0);
      end
      ST_ERR: begin
        issue      = s1_adv;
        issue_kind = KIND_ERROR;
        issue_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign job_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      chunk_q    <= '0;
      nd_q       <= '0;
      rd_ptr_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        chunk_q <= '0;
        nd_q    <= '0;
      end else if (state_q == ST_DIV) begin
        if (div_done) begin
          chunk_q  <= '0;
          nd_q     <= nd_q + 1'b1;
          rd_ptr_q <= nd_q[ADDR_W-1:0];
        end else begin
          chunk_q <= chunk_q + 1'b1;
        end
      end else if (issue && (state_q == ST_DIGITS)) begin
        rd_ptr_q <= rd_ptr_q - 1'b1;
      end
      if (s1_adv) begin
        s1_valid_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ctrl_q <= job_ctrl_i;
      quo_q  <= DIV_W'(job_mag_i);
      rem_q  <= '0;
    end else if (state_q == ST_DIV) begin
      quo_q <= div_quo;
      rem_q <= div_done ? '0 : div_rem;
    end
    if (s1_adv) begin
      s1_kind_q  <= issue_kind;
      s1_last_q  <= issue_last;
      s1_upper_q <= ctrl_q.upper;
    end
  end

  // digit stack, least significant digit at address 0
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DIV) && div_done) begin
      digit_mem[nd_q[ADDR_W-1:0]] <= div_rem;
    end
    if (issue && (state_q == ST_DIGITS)) begin
      rd_data_q <= digit_mem[rd_ptr_q];
    end
  end

  assign out_push_o = s1_valid_q && !out_full_i;

  always_comb begin
    out_item_o.last  = s1_last_q;
    out_item_o.error = (s1_kind_q == KIND_ERROR);
    case (s1_kind_q)
      KIND_DIGIT: out_item_o.character = digit_char(rd_data_q, s1_upper_q);
      KIND_MINUS: out_item_o.character = CHAR_MINUS;
      default:    out_item_o.character = CHAR_NUL;
    endcase
  end

endmodule

`default_nettype wire

/* sim/itoa_text_checker.sv */
`timescale 1ns / 1ps

module itoa_text_checker #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [itoa_pkg::CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [itoa_pkg::CFG_DATA_W-1:0] wr_data_i,
  input  logic                            push,
  input  logic                            full,
  input  logic [itoa_pkg::VALUE_W-1:0]    value_i,
  input  logic                            empty,
  input  logic                            pop,
  input  logic [itoa_pkg::CHAR_W-1:0]     character_i,
  input  logic                            last_i,
  input  logic                            error_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import itoa_pkg::*;

  logic [RADIX_W-1:0] radix_q;
  logic               upper_q;
  out_item_t          expected_chars[$];
  out_item_t          oldest;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // queues the characters of one value's text under the current settings
  function automatic void predict_text(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mask;
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] base;
    logic [DIGIT_W-1:0] d;
    logic [CHAR_W-1:0]  digits[$];
    logic               neg;
    mask = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);
    raw  = value & mask;
    neg  = raw[VALUE_BITS-1];
    if (radix_q < RADIX_MIN || radix_q > RADIX_MAX) begin
      expected_chars.push_back(out_item_t'{CHAR_NUL, 1'b1, 1'b1});
      return;
    end
    mag  = neg ? ((~raw + 1'b1) & mask) : raw;
    base = VALUE_W'(radix_q);
    if (mag == '0) begin
      digits.push_front(CHAR_ZERO);
    end
    while (mag != '0) begin
      d = DIGIT_W'(mag % base);
      if (d < 4'd10) begin
        digits.push_front(CHAR_ZERO + CHAR_W'(d));
      end else begin
        digits.push_front((upper_q ? 8'h41 : 8'h61) + CHAR_W'(d) - 8'd10);
      end
      mag = mag / base;
    end
    if (neg && radix_q == RADIX_DEC) begin
      expected_chars.push_back(out_item_t'{CHAR_MINUS, 1'b0, 1'b0});
    end
    foreach (digits[i]) begin
      expected_chars.push_back(out_item_t'{digits[i], i == digits.size() - 1, 1'b0});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q = RADIX_RESET;
      upper_q = 1'b0;
      expected_chars.delete();
    end else begin
      // a transaction at the edge of a register write still sees the old settings
      if (push && !full) begin
        predict_text(value_i);
      end
      if (wr_en_i) begin
        case (wr_idx_i)
          REG_RADIX: radix_q = wr_data_i;
          REG_UPPER: upper_q = wr_data_i[0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $error("character: expected none, actual %h", character_i);
          fail_count_o++;
        end else begin
          oldest = expected_chars.pop_front();
          if (character_i !== oldest.character) begin
            $error("character: expected %h, actual %h", oldest.character, character_i);
            fail_count_o++;
          end
          if (last_i !== oldest.last) begin
            $error("last: expected %b, actual %b", oldest.last, last_i);
            fail_count_o++;
          end
          if (error_i !== oldest.error) begin
            $error("error: expected %b, actual %b", oldest.error, error_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_chars.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import itoa_pkg::*;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_idx  = REG_RADIX;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic                  push    = 1'b0;
  logic [VALUE_W-1:0]    value   = '0;
  logic                  pop     = 1'b0;
  logic                  full;
  logic                  empty;
  logic [CHAR_W-1:0]     text_char;
  logic                  text_last;
  logic                  text_error;
  int                    fail_count;
  int                    pending;
  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;

  integer_to_radix_ascii_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_data_i  (wr_data),
    .push       (push),
    .full       (full),
    .value_i    (value),
    .empty      (empty),
    .pop        (pop),
    .character_o(text_char),
    .last_o     (text_last),
    .error_o    (text_error)
  );

  itoa_text_checker u_text_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_idx_i    (wr_idx),
    .wr_data_i   (wr_data),
    .push        (push),
    .full        (full),
    .value_i     (value),
    .empty       (empty),
    .pop         (pop),
    .character_i (text_char),
    .last_i      (text_last),
    .error_i     (text_error),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // entered and left at a rising edge; push stays high after the transaction
  task automatic send_value(input logic [VALUE_W-1:0] v);
    logic room;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push  <= 1'b1;
    value <= v;
    do begin
      @(negedge clk_i);
      room = !full;
      @(posedge clk_i);
    end while (!room);
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] radix, input logic upper);
    wr_en   <= 1'b1;
    wr_idx  <= REG_RADIX;
    wr_data <= radix;
    @(posedge clk_i);
    wr_idx  <= REG_UPPER;
    wr_data <= CFG_DATA_W'(upper);
    @(posedge clk_i);
    wr_en   <= 1'b0;
  endtask

  task automatic run_set(input logic [CFG_DATA_W-1:0] radix, input logic upper,
                         input logic [VALUE_W-1:0] vals[$]);
    drain();
    set_config(radix, upper);
    foreach (vals[i]) begin
      send_value(vals[i]);
    end
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = {$urandom, $urandom};
      4, 5:       v = VALUE_W'($urandom_range(1000));
      6:          v = $urandom_range(1) ? 64'h7fff_ffff_ffff_ffff - $urandom_range(20)
                                        : 64'h8000_0000_0000_0000 + $urandom_range(20);
      7:          v = 64'd1 << $urandom_range(63);
      default:    v = {{32{1'b0}}, $urandom} ^ {64{$urandom_range(1) == 1}};
    endcase
    if ($urandom_range(3) == 0) begin
      v = -v;
    end
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_radix();
    if ($urandom_range(7) == 0) begin
      return $urandom_range(1) ? CFG_DATA_W'($urandom_range(1))
                               : CFG_DATA_W'($urandom_range(31, 17));
    end
    return CFG_DATA_W'($urandom_range(16, 2));
  endfunction

  initial begin
    logic [VALUE_W-1:0] reset_vals[$];
    reset_vals = '{64'd0, 64'd1, -64'd1, 64'd9, 64'd10,
                   64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: base 10, lower case
    foreach (reset_vals[i]) begin
      send_value(reset_vals[i]);
    end
    run_set(5'd16, 1'b1, '{-64'd1, 64'hfedc_ba98_7654_3210, 64'h8000_0000_0000_0000,
                           64'h0000_0000_0abc_def0});
    run_set(5'd16, 1'b0, '{64'hfedc_ba98_7654_3210});
    run_set(5'd2, 1'b0, '{64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 64'd0});
    run_set(5'd3, 1'b1, '{64'h8000_0000_0000_0000});
    run_set(5'd0, 1'b0, '{64'd5});
    run_set(5'd1, 1'b0, '{-64'd5});
    run_set(5'd17, 1'b1, '{64'd0});
    run_set(5'd31, 1'b0, '{64'h8000_0000_0000_0000});

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      set_config(random_radix(), 1'($urandom_range(1)));
      repeat (14) send_value(random_value());
    end

    drain();
    repeat (600) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #1_500_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
